// File: rtl/mpecd_pkg.sv
`timescale 1ns / 1ps
package mpecd_pkg;

	// Block sizing
	localparam int CHANNELS    = 16;
	localparam int SELECT_BITS = 4;
	localparam int SAMPLE_BITS = 10;

	// Fixed field and register widths
	localparam int CHAN_W   = 4;
	localparam int SEL_W    = 4;
	localparam int WEIGHT_W = 9;
	localparam int THR_W    = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;
	localparam int STORE_DEPTH = 16;

	// Datapath widths
	localparam int PROD_W = SAMPLE_BITS + WEIGHT_W;
	localparam int CMP_W  = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
	localparam int SCAN_W = CHAN_W + 1;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE      = WEIGHT_W'(256);
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET    = WEIGHT_W'(154);
	localparam logic [THR_W-1:0]    THRESHOLD_RESET = THR_W'(4);
	localparam logic [SCAN_W-1:0]   SCAN_LIMIT      = SCAN_W'(CHANNELS);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EMA_WEIGHT       = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD = CFG_IDX_W'(1);

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] filtered;
		logic                   changed;
	} ema_result_t;

endpackage

// File: rtl/mpecd_datapath.sv
`timescale 1ns / 1ps
module mpecd_datapath (
	input  logic [mpecd_pkg::WEIGHT_W-1:0]    weight,
	input  logic [mpecd_pkg::THR_W-1:0]       threshold,
	input  logic [mpecd_pkg::SAMPLE_BITS-1:0] sample,
	input  logic [mpecd_pkg::SAMPLE_BITS-1:0] old_value,
	input  logic [mpecd_pkg::SAMPLE_BITS-1:0] reported,
	output mpecd_pkg::ema_result_t            result
);

	logic [mpecd_pkg::WEIGHT_W-1:0]    w_sat;
	logic [mpecd_pkg::WEIGHT_W-1:0]    w_inv;
	logic [mpecd_pkg::PROD_W-1:0]      prod_new;
	logic [mpecd_pkg::PROD_W-1:0]      prod_old;
	logic [mpecd_pkg::PROD_W-1:0]      blend;
	logic [mpecd_pkg::SAMPLE_BITS-1:0] val;
	logic [mpecd_pkg::SAMPLE_BITS-1:0] diff;

	// weights above one saturate
	assign w_sat = (weight > mpecd_pkg::WEIGHT_ONE) ? mpecd_pkg::WEIGHT_ONE : weight;
	assign w_inv = mpecd_pkg::WEIGHT_ONE - w_sat;

	assign prod_new = mpecd_pkg::PROD_W'(w_sat) * mpecd_pkg::PROD_W'(sample);
	assign prod_old = mpecd_pkg::PROD_W'(w_inv) * mpecd_pkg::PROD_W'(old_value);
	// sum stays below 2^(SAMPLE_BITS+8), no carry lost
	assign blend    = prod_new + prod_old;
	assign val      = blend[mpecd_pkg::SAMPLE_BITS+7:8];

	assign diff = (val >= reported) ? (val - reported) : (reported - val);

	assign result.filtered = val;
	assign result.changed  = mpecd_pkg::CMP_W'(diff) > mpecd_pkg::CMP_W'(threshold);

endmodule

// File: rtl/muxed_pot_ema_change_detector_core.sv
`timescale 1ns / 1ps
// An accepted sample beat passes the input register s1, then the result register s2.
// Throughput: one sample per cycle while out_stall is low; set by the single
//   blend-and-compare pass between the input register and the result register.
// Reset (arst_n low, asynchronous): both channel stores cleared to zero,
//   scan counter to channel 0, weight 154, threshold 4, no beats held.
module muxed_pot_ema_change_detector_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [mpecd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mpecd_pkg::CFG_DATA_W-1:0]    cfg_data,
	// sample channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [mpecd_pkg::SAMPLE_BITS-1:0]   sample,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [mpecd_pkg::CHAN_W-1:0]        channel,
	output logic [mpecd_pkg::SAMPLE_BITS-1:0]   filtered_value,
	output logic                                value_changed,
	output logic [mpecd_pkg::SEL_W-1:0]         next_select
);

	// Configuration registers
	logic [mpecd_pkg::WEIGHT_W-1:0] weight_q;
	logic [mpecd_pkg::THR_W-1:0]    threshold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q    <= mpecd_pkg::WEIGHT_RESET;
			threshold_q <= mpecd_pkg::THRESHOLD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mpecd_pkg::REG_EMA_WEIGHT:       weight_q <= cfg_data[mpecd_pkg::WEIGHT_W-1:0];
				mpecd_pkg::REG_CHANGE_THRESHOLD: threshold_q <= cfg_data[mpecd_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: s1 holds the accepted sample, s2 is the result register.
	logic s1_valid;
	logic s2_valid;
	logic s2_load;
	logic s1_move;
	logic in_take;

	assign s2_load  = !s2_valid || !out_stall;
	assign s1_move  = s1_valid && s2_load;
	assign in_stall = s1_valid && !s2_load;
	assign in_take  = in_valid && !in_stall;

	// Scan counter: channel tag for the next accepted beat
	logic [mpecd_pkg::CHAN_W-1:0] scan_q;
	logic [mpecd_pkg::SCAN_W-1:0] scan_inc;
	logic [mpecd_pkg::CHAN_W-1:0] scan_next;

	assign scan_inc  = mpecd_pkg::SCAN_W'(scan_q) + mpecd_pkg::SCAN_W'(1);
	// wrap at CHANNELS; anything at or past the limit also returns to zero
	assign scan_next = (scan_inc >= mpecd_pkg::SCAN_LIMIT) ? '0
	                                                       : scan_inc[mpecd_pkg::CHAN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (in_take) begin
			scan_q <= scan_next;
		end
	end

	// Stage 1 registers
	logic [mpecd_pkg::SAMPLE_BITS-1:0] sample_s1;
	logic [mpecd_pkg::CHAN_W-1:0]      chan_s1;
	logic [mpecd_pkg::CHAN_W-1:0]      next_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_take) begin
			s1_valid <= 1'b1;
		end else if (s1_move) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_s1 <= sample;
			chan_s1   <= scan_q;
			next_s1   <= scan_next;
		end
	end

	// Per-channel stores. Written when the s1 beat leaves, so the next
	// beat in s1 always sees the updated entry, even on a single channel.
	logic [mpecd_pkg::SAMPLE_BITS-1:0] filt_q [mpecd_pkg::STORE_DEPTH];
	logic [mpecd_pkg::SAMPLE_BITS-1:0] rep_q  [mpecd_pkg::STORE_DEPTH];
	mpecd_pkg::ema_result_t            res;

	mpecd_datapath u_datapath (
		.weight    (weight_q),
		.threshold (threshold_q),
		.sample    (sample_s1),
		.old_value (filt_q[chan_s1]),
		.reported  (rep_q[chan_s1]),
		.result    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mpecd_pkg::STORE_DEPTH; i++) begin
				filt_q[i] <= '0;
				rep_q[i]  <= '0;
			end
		end else if (s1_move) begin
			filt_q[chan_s1] <= res.filtered;
			if (res.changed) begin
				rep_q[chan_s1] <= res.filtered;
			end
		end
	end

	// Stage 2: result register
	logic [mpecd_pkg::CHAN_W-1:0]      chan_s2;
	logic [mpecd_pkg::SAMPLE_BITS-1:0] filt_s2;
	logic                              chg_s2;
	logic [mpecd_pkg::CHAN_W-1:0]      next_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (s2_load) begin
			s2_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			chan_s2 <= chan_s1;
			filt_s2 <= res.filtered;
			chg_s2  <= res.changed;
			next_s2 <= next_s1;
		end
	end

	assign out_valid      = s2_valid;
	assign channel        = chan_s2;
	assign filtered_value = filt_s2;
	assign value_changed  = chg_s2;
	// mux select carries only the low SELECT_BITS of the next channel
	assign next_select    = mpecd_pkg::SEL_W'(next_s2[mpecd_pkg::SELECT_BITS-1:0]);

endmodule
